@@ sv/assert_macros.svh @@
// Assertion macros, included by the serializer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/lmfs_pkg.sv @@
// Types and constants of the LED matrix frame serializer.
package lmfs_pkg;

    localparam int ROWS          = 12;
    localparam int COLS          = 12;
    localparam int ROW_ADDR_STEP = 4;
    localparam int ROW_AW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_AW        = $clog2(COLS);

    localparam logic [2:0] KIND_SET_PIXEL  = 3'd0;
    localparam logic [2:0] KIND_GET_PIXEL  = 3'd1;
    localparam logic [2:0] KIND_FILL       = 3'd2;
    localparam logic [2:0] KIND_WRITE_FRAME = 3'd3;
    localparam logic [2:0] KIND_BRIGHTNESS = 3'd4;

    localparam logic [4:0] FRAME_DATA_LEN = 5'd22;
    localparam logic [4:0] FRAME_CMD_LEN  = 5'd12;
    localparam logic [2:0] DATA_ID        = 3'b101;
    localparam logic [2:0] CMD_ID         = 3'b100;
    localparam logic [3:0] BRIGHT_BASE    = 4'hA;
    localparam logic [7:0] LEVEL_MAX      = 8'd15;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic       pixel_value;
        logic [7:0] level;
    } cmd_t;

    typedef struct packed {
        logic [21:0] frame_bits;
        logic [4:0]  frame_length;
        logic        pixel_bit;
        logic        last;
    } res_t;

    typedef struct packed {
        logic              rd_en;
        logic [ROW_AW-1:0] rd_addr;
        logic              wr_en;
        logic [ROW_AW-1:0] wr_addr;
        logic [COLS-1:0]   wr_data;
        logic              fill_en;
        logic              fill_val;
    } store_req_t;

endpackage

@@ sv/lmfs_row_store.sv @@
// Pixel row memory with per-row valid bits and a whole-store fill value.
module lmfs_row_store
    import lmfs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  store_req_t      req,
    output logic [COLS-1:0] rd_data
);

    logic [COLS-1:0] mem [ROWS];
    logic [ROWS-1:0] valid_reg;
    logic [ROWS-1:0] valid_next;
    logic            fill_reg;
    logic            fill_next;
    logic [COLS-1:0] mem_q_reg;
    logic            valid_q_reg;
    logic            fill_q_reg;

    always_comb
    begin
        valid_next = valid_reg;
        fill_next  = fill_reg;
        if (req.fill_en)
        begin
            valid_next = '0;
            fill_next  = req.fill_val;
        end
        else if (req.wr_en)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fill_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg   <= mem[req.rd_addr];
            valid_q_reg <= valid_reg[req.rd_addr];
            fill_q_reg  <= fill_reg;
        end
    end

    // rows untouched since the last fill read as the fill value
    assign rd_data = valid_q_reg ? mem_q_reg : {COLS{fill_q_reg}};

endmodule

@@ sv/led_matrix_framebuffer_serializer_top.sv @@
// Top level of the LED matrix frame serializer.
// Commands arrive one word at a time on cmd; results leave on res. Set pixel
// and get pixel are accepted with a row read, then modify the row or answer;
// fill acts on acceptance, brightness answers after it, and write frame sends
// one data frame per row since each data frame needs one read of the row memory.
// A finished result waits in the output register while the next command is
// taken. The store reads as all zero after reset with no clearing pass.
module led_matrix_framebuffer_serializer_top
    import lmfs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

`include "assert_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PIX  = 2'd1;
    localparam logic [1:0] S_ROW  = 2'd2;

    logic [1:0]        state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic              inside_reg, inside_next;
    logic [ROW_AW-1:0] row_reg, row_next;
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    store_req_t        req;
    logic [COLS-1:0]   row_data;
    logic [COLS-1:0]   row_mod;
    logic [COL_AW-1:0] bit_idx;
    logic              in_range;
    logic              out_free;
    logic              row_last;
    logic [6:0]        row_addr;
    logic [3:0]        lv;

    lmfs_row_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_data (row_data)
    );

    assign in_range = (cmd.x_pos < 8'(COLS)) && (cmd.y_pos < 8'(ROWS));
    assign out_free = !res_valid_reg || !res_stall;
    assign bit_idx  = COL_AW'(COLS - 1) - cmd_reg.x_pos[COL_AW-1:0];
    assign row_last = (row_reg == ROW_AW'(ROWS - 1));
    assign row_addr = 7'(32'(row_reg) * ROW_ADDR_STEP);
    assign lv       = (cmd_reg.level > LEVEL_MAX) ? 4'hF : cmd_reg.level[3:0];

    always_comb
    begin
        row_mod          = row_data;
        row_mod[bit_idx] = cmd_reg.pixel_value;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        inside_next    = inside_reg;
        row_next       = row_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        req            = '0;
        req.rd_addr    = cmd.y_pos[ROW_AW-1:0];
        req.wr_addr    = cmd_reg.y_pos[ROW_AW-1:0];
        req.wr_data    = row_mod;
        req.fill_val   = cmd.pixel_value;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd;
                    inside_next = in_range;
                    case (cmd.kind)
                        KIND_SET_PIXEL, KIND_GET_PIXEL:
                        begin
                            req.rd_en  = in_range;
                            state_next = S_PIX;
                        end
                        KIND_FILL:
                        begin
                            req.fill_en = 1'b1;
                        end
                        KIND_WRITE_FRAME:
                        begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = '0;
                            row_next    = '0;
                            state_next  = S_ROW;
                        end
                        KIND_BRIGHTNESS:
                        begin
                            state_next = S_PIX;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PIX:
            begin
                case (cmd_reg.kind)
                    KIND_SET_PIXEL:
                    begin
                        req.wr_en  = inside_reg;
                        state_next = S_IDLE;
                    end
                    KIND_GET_PIXEL:
                    begin
                        if (out_free)
                        begin
                            res_valid_next        = 1'b1;
                            res_next.frame_bits   = '0;
                            res_next.frame_length = '0;
                            res_next.pixel_bit    = inside_reg && row_data[bit_idx];
                            res_next.last         = 1'b1;
                            state_next            = S_IDLE;
                        end
                    end
                    KIND_BRIGHTNESS:
                    begin
                        if (out_free)
                        begin
                            res_valid_next        = 1'b1;
                            res_next.frame_bits   = {10'd0, CMD_ID, BRIGHT_BASE, lv, 1'b0};
                            res_next.frame_length = FRAME_CMD_LEN;
                            res_next.pixel_bit    = 1'b0;
                            res_next.last         = 1'b1;
                            state_next            = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_ROW:
            begin
                if (out_free)
                begin
                    res_valid_next        = 1'b1;
                    res_next.frame_bits   = {DATA_ID, row_addr, row_data};
                    res_next.frame_length = FRAME_DATA_LEN;
                    res_next.pixel_bit    = 1'b0;
                    res_next.last         = row_last;
                    if (row_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next    = row_reg + 1'b1;
                        req.rd_en   = 1'b1;
                        req.rd_addr = row_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        inside_reg <= inside_next;
        row_reg    <= row_next;
        res_reg    <= res_next;
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `ASSERT_IMPL(a_no_wr_with_fill, req.wr_en, !req.fill_en, "row write during fill")
    `ASSERT_IMPL(a_row_in_range, state_reg == S_ROW, row_reg <= ROW_AW'(ROWS - 1),
                 "frame row counter beyond last row")
    `ASSERT_IMPL(a_empty_is_last, res_valid && res.frame_length == 5'd0, res.last,
                 "pixel answer not marked last")
    `ASSERT_NEXT(a_frame_start,
                 cmd_valid && !cmd_stall && cmd.kind == KIND_WRITE_FRAME,
                 state_reg == S_ROW && row_reg == '0, "write frame did not start at row 0")

endmodule
